>>> hw/rtl/mhpq_pkg.sv
package mhpq_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  // child index may reach twice the capacity
  localparam int CIDX_W   = ADDR_W + 2;

  localparam int KEY_W = 8;
  localparam int PRI_W = 16;
  localparam int OCC_W = 7;
  localparam int ST_W  = 2;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PRI_W-1:0] pri;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_UP,
    S_INS_CMP,
    S_DEL_ROOT,
    S_DEL_LAST,
    S_DEL_LOAD,
    S_DN_L,
    S_DN_R,
    S_DN_C,
    S_DN_MOVE
  } state_t;

endpackage

>>> hw/rtl/mhpq_ram.sv
module mhpq_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/min_heap_priority_queue_top.sv
// binary min-heap priority queue of key/priority entries. pulse start with
// busy low to hand in one beat: cmd 0 inserts entry_key/entry_priority, cmd 1
// removes the entry of smallest priority. each beat gives exactly one result,
// shown for a single cycle with done high; the receiver cannot stall, so it
// must take the result in that cycle. the next beat may be handed in during
// the result cycle. a beat that finds the heap empty (remove) or full
// (insert) answers without a heap access. an insert climbs one level at a
// time and a remove descends one level at a time; the pace is set by the
// single registered read port of the heap ram: every parent or child is
// fetched one at a time and compared by one shared priority comparator.
// equal priorities never pass each other. the heap ram holds no reset value;
// only data read from slots below the count is ever used.
module min_heap_priority_queue_top (
  input  logic                      clk,
  input  logic                      rst,
  // command channel
  input  logic                      start,
  output logic                      busy,
  input  logic                      cmd,
  input  logic [mhpq_pkg::KEY_W-1:0] entry_key,
  input  logic [mhpq_pkg::PRI_W-1:0] entry_priority,
  // result channel, one cycle strobe
  output logic                      done,
  output logic [mhpq_pkg::ST_W-1:0]  status,
  output logic [mhpq_pkg::KEY_W-1:0] out_key,
  output logic [mhpq_pkg::PRI_W-1:0] out_priority,
  output logic [mhpq_pkg::OCC_W-1:0] occupancy
);

  // sequencer state
  mhpq_pkg::state_t state, state_next;

  // entry count and the slot being worked on
  logic [mhpq_pkg::CNT_W-1:0]  count;
  logic [mhpq_pkg::ADDR_W-1:0] idx;

  // entry that is moving (new entry on insert, last entry on remove)
  mhpq_pkg::entry_t cur;
  // smallest of the current slot and its children seen so far
  mhpq_pkg::entry_t best;
  logic [mhpq_pkg::ADDR_W-1:0] best_idx;
  // removed root, held until the result beat
  mhpq_pkg::entry_t root;

  // ram ports
  logic                        ram_we;
  logic [mhpq_pkg::ADDR_W-1:0] ram_waddr;
  mhpq_pkg::entry_t            ram_wdata;
  logic [mhpq_pkg::ADDR_W-1:0] ram_raddr;
  logic [mhpq_pkg::ENTRY_W-1:0] ram_rdata;
  mhpq_pkg::entry_t            rd;

  // shared priority comparator
  logic [mhpq_pkg::PRI_W-1:0] cmp_a, cmp_b;
  logic                       cmp_lt;

  // index arithmetic
  logic [mhpq_pkg::ADDR_W-1:0] parent_idx;
  logic [mhpq_pkg::CIDX_W-1:0] left_idx, right_idx, count_ext;
  logic                        has_left, has_right;
  logic                        full, empty;
  logic                        accept;
  logic                        finish;

  assign rd = mhpq_pkg::entry_t'(ram_rdata);

  assign parent_idx = (idx - mhpq_pkg::ADDR_W'(1)) >> 1;
  assign left_idx   = mhpq_pkg::CIDX_W'({idx, 1'b1});
  assign right_idx  = left_idx + mhpq_pkg::CIDX_W'(1);
  assign count_ext  = mhpq_pkg::CIDX_W'(count);
  assign has_left   = left_idx < count_ext;
  assign has_right  = right_idx < count_ext;
  assign full       = count >= mhpq_pkg::CNT_W'(mhpq_pkg::CAPACITY);
  assign empty      = count == '0;

  assign busy   = state != mhpq_pkg::S_IDLE;
  assign accept = start && !busy;
  assign cmp_lt = cmp_a < cmp_b;

  mhpq_ram #(
    .WIDTH (mhpq_pkg::ENTRY_W),
    .DEPTH (mhpq_pkg::CAPACITY)
  ) u_heap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      mhpq_pkg::S_IDLE: begin
        if (accept) begin
          if (cmd == mhpq_pkg::CMD_INSERT) begin
            if (!full) state_next = mhpq_pkg::S_INS_UP;
          end else begin
            if (!empty) state_next = mhpq_pkg::S_DEL_ROOT;
          end
        end
      end
      mhpq_pkg::S_INS_UP: begin
        state_next = (idx == '0) ? mhpq_pkg::S_IDLE : mhpq_pkg::S_INS_CMP;
      end
      mhpq_pkg::S_INS_CMP: begin
        state_next = cmp_lt ? mhpq_pkg::S_INS_UP : mhpq_pkg::S_IDLE;
      end
      mhpq_pkg::S_DEL_ROOT: state_next = mhpq_pkg::S_DEL_LAST;
      mhpq_pkg::S_DEL_LAST: state_next = mhpq_pkg::S_DEL_LOAD;
      mhpq_pkg::S_DEL_LOAD: state_next = mhpq_pkg::S_DN_L;
      mhpq_pkg::S_DN_L: begin
        state_next = has_left ? mhpq_pkg::S_DN_R : mhpq_pkg::S_IDLE;
      end
      mhpq_pkg::S_DN_R: begin
        state_next = has_right ? mhpq_pkg::S_DN_C : mhpq_pkg::S_DN_MOVE;
      end
      mhpq_pkg::S_DN_C: state_next = mhpq_pkg::S_DN_MOVE;
      mhpq_pkg::S_DN_MOVE: begin
        state_next = (best_idx == idx) ? mhpq_pkg::S_IDLE : mhpq_pkg::S_DN_L;
      end
      default: state_next = mhpq_pkg::S_IDLE;
    endcase
  end

  // ram control, comparator operands and completion
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = cur;
    ram_raddr = '0;
    cmp_a     = rd.pri;
    cmp_b     = cur.pri;
    finish    = 1'b0;
    case (state)
      mhpq_pkg::S_INS_UP: begin
        // top reached: the new entry lands at the root
        if (idx == '0) begin
          ram_we = 1'b1;
          finish = 1'b1;
        end
        ram_raddr = parent_idx;
      end
      mhpq_pkg::S_INS_CMP: begin
        cmp_a  = cur.pri;
        cmp_b  = rd.pri;
        ram_we = 1'b1;
        if (cmp_lt) begin
          // parent moves down into the hole
          ram_wdata = rd;
        end else begin
          finish = 1'b1;
        end
      end
      mhpq_pkg::S_DEL_ROOT: ram_raddr = '0;
      mhpq_pkg::S_DEL_LAST: begin
        ram_raddr = mhpq_pkg::ADDR_W'(count - mhpq_pkg::CNT_W'(1));
      end
      mhpq_pkg::S_DN_L: begin
        ram_raddr = left_idx[mhpq_pkg::ADDR_W-1:0];
        if (!has_left) begin
          ram_we = 1'b1;
          finish = 1'b1;
        end
      end
      mhpq_pkg::S_DN_R: begin
        ram_raddr = right_idx[mhpq_pkg::ADDR_W-1:0];
        cmp_a     = rd.pri;
        cmp_b     = cur.pri;
      end
      mhpq_pkg::S_DN_C: begin
        cmp_a = rd.pri;
        cmp_b = best.pri;
      end
      mhpq_pkg::S_DN_MOVE: begin
        ram_we = 1'b1;
        if (best_idx == idx) begin
          finish = 1'b1;
        end else begin
          // smaller child moves up into the hole
          ram_wdata = best;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mhpq_pkg::S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      // empty remove and full insert answer straight away
      done  <= finish ||
               (accept && ((cmd == mhpq_pkg::CMD_INSERT) ? full : empty));
      if (accept && cmd == mhpq_pkg::CMD_INSERT && !full) begin
        count <= count + mhpq_pkg::CNT_W'(1);
      end
      if (state == mhpq_pkg::S_DEL_LAST) begin
        count <= count - mhpq_pkg::CNT_W'(1);
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      mhpq_pkg::S_IDLE: begin
        if (accept) begin
          cur.key <= entry_key;
          cur.pri <= entry_priority;
          idx     <= count[mhpq_pkg::ADDR_W-1:0];
          root    <= '0;
          if (cmd == mhpq_pkg::CMD_INSERT) begin
            status <= full ? mhpq_pkg::ST_FULL : mhpq_pkg::ST_OK;
          end else begin
            status <= empty ? mhpq_pkg::ST_EMPTY : mhpq_pkg::ST_OK;
          end
        end
      end
      mhpq_pkg::S_INS_CMP: begin
        if (cmp_lt) idx <= parent_idx;
      end
      mhpq_pkg::S_DEL_LAST: root <= rd;
      mhpq_pkg::S_DEL_LOAD: begin
        cur <= rd;
        idx <= '0;
      end
      mhpq_pkg::S_DN_R: begin
        if (cmp_lt) begin
          best     <= rd;
          best_idx <= left_idx[mhpq_pkg::ADDR_W-1:0];
        end else begin
          best     <= cur;
          best_idx <= idx;
        end
      end
      mhpq_pkg::S_DN_C: begin
        if (cmp_lt) begin
          best     <= rd;
          best_idx <= right_idx[mhpq_pkg::ADDR_W-1:0];
        end
      end
      mhpq_pkg::S_DN_MOVE: idx <= best_idx;
      default: ;
    endcase
  end

  // result beat: removed entry is zero unless a remove succeeded
  assign out_key      = root.key;
  assign out_priority = root.pri;
  assign occupancy    = mhpq_pkg::OCC_W'(count);

endmodule
